[src/i2cee_pkg.sv]
package i2cee_pkg;

    localparam int unsigned BUF_DEPTH_DEF = 256;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_EVENT = 2'd3;

    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_START = 3'd1;
    localparam logic [2:0] ACT_AWR   = 3'd2;
    localparam logic [2:0] ACT_ARD   = 3'd3;
    localparam logic [2:0] ACT_SEND  = 3'd4;
    localparam logic [2:0] ACT_STOP  = 3'd5;

    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_R_START   = 4'd1;
    localparam logic [3:0] PH_R_WADDR   = 4'd2;
    localparam logic [3:0] PH_R_WADDR2  = 4'd3;
    localparam logic [3:0] PH_R_DAWRITE = 4'd4;
    localparam logic [3:0] PH_R_ADDR    = 4'd5;
    localparam logic [3:0] PH_R_MODE    = 4'd6;
    localparam logic [3:0] PH_R_RECV    = 4'd7;
    localparam logic [3:0] PH_T_START   = 4'd8;
    localparam logic [3:0] PH_T_ADDR    = 4'd9;
    localparam logic [3:0] PH_T_ADDR2   = 4'd10;
    localparam logic [3:0] PH_T_NEXT    = 4'd11;
    localparam logic [3:0] PH_T_LAST    = 4'd12;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 32;

    typedef struct packed {
        logic       nack_seen;
        logic       byte_done;
        logic       rx_full;
        logic       tx_empty;
        logic       addr_acked;
        logic       start_sent;
        logic [7:0] load_index;
        logic [7:0] data_byte;
        logic [8:0] length;
        logic [12:0] mem_addr;
        logic [6:0] dev_addr;
    } item_t;

    typedef struct packed {
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic [7:0] rx_index;
        logic       rx_valid;
        logic       ack_enable;
        logic [7:0] tx_byte;
        logic [2:0] bus_action;
    } res_t;

    // Reduces a buffer position modulo the store depth by shifted compare and subtract.
    function automatic logic [8:0] pos_mod(input logic [8:0] pos, input int unsigned depth);
        logic [8:0]  v;
        logic [21:0] sub;
        v = pos;
        for (int k = 8; k >= 0; k--)
        begin
            sub = 22'(depth) << k;
            if ({13'd0, v} >= sub)
            begin
                v = v - sub[8:0];
            end
        end
        return v;
    endfunction

endpackage

[src/i2cee_ram.sv]
module i2cee_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[src/i2cee_ctrl.sv]
module i2cee_ctrl #(
    parameter int unsigned BUF_DEPTH = i2cee_pkg::BUF_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    input  logic [1:0]         cmd,
    input  i2cee_pkg::item_t   item,
    output i2cee_pkg::res_t    res
);
    import i2cee_pkg::*;

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    logic [3:0]  phase_reg, phase_next;
    logic [6:0]  slave_reg, slave_next;
    logic [12:0] maddr_reg, maddr_next;
    logic [8:0]  count_reg, count_next;
    logic [8:0]  pos_reg, pos_next;
    logic        ack_reg, ack_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic [7:0]    store_byte;

    logic          fwd_valid_reg;
    logic [AW-1:0] fwd_addr_reg;
    logic [7:0]    fwd_data_reg;
    logic [AW-1:0] rd_addr_reg;

    assign wr_en   = in_fire && (cmd == CMD_LOAD);
    assign wr_addr = AW'(pos_mod({1'b0, item.load_index}, BUF_DEPTH));
    assign rd_addr = AW'(pos_mod(pos_next, BUF_DEPTH));

    i2cee_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (item.data_byte),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // A load in the cycle of the read returns old data, so the loaded byte is forwarded.
    assign store_byte = (fwd_valid_reg && (fwd_addr_reg == rd_addr_reg)) ? fwd_data_reg
                                                                          : rd_data;

    always_comb
    begin
        phase_next = phase_reg;
        slave_next = slave_reg;
        maddr_next = maddr_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        ack_next   = ack_reg;
        res        = '0;
        if (in_fire)
        begin
            case (cmd)
                CMD_LOAD:
                begin
                end
                CMD_READ, CMD_WRITE:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        slave_next = item.dev_addr;
                        maddr_next = item.mem_addr;
                        count_next = item.length;
                        pos_next   = '0;
                        if (cmd == CMD_READ)
                        begin
                            ack_next   = 1'b1;
                            phase_next = PH_R_START;
                        end
                        else
                        begin
                            phase_next = PH_T_START;
                        end
                        res.bus_action = ACT_START;
                    end
                end
                default:
                begin
                    case (phase_reg)
                        PH_R_START, PH_T_START:
                        begin
                            if (item.start_sent)
                            begin
                                res.bus_action = ACT_AWR;
                                res.tx_byte    = {slave_reg, 1'b0};
                                phase_next     = (phase_reg == PH_R_START) ? PH_R_WADDR
                                                                           : PH_T_ADDR;
                            end
                        end
                        PH_R_WADDR:
                        begin
                            if (item.addr_acked)
                            begin
                                res.bus_action = ACT_SEND;
                                res.tx_byte    = {3'd0, maddr_reg[12:8]};
                                phase_next     = PH_R_WADDR2;
                            end
                        end
                        PH_R_WADDR2, PH_T_ADDR2:
                        begin
                            if (item.tx_empty)
                            begin
                                res.bus_action = ACT_SEND;
                                res.tx_byte    = maddr_reg[7:0];
                                phase_next     = (phase_reg == PH_R_WADDR2) ? PH_R_DAWRITE
                                                                            : PH_T_NEXT;
                            end
                        end
                        PH_R_DAWRITE:
                        begin
                            if (item.tx_empty)
                            begin
                                res.bus_action = ACT_START;
                                phase_next     = PH_R_ADDR;
                            end
                        end
                        PH_R_ADDR:
                        begin
                            if (item.start_sent)
                            begin
                                res.bus_action = ACT_ARD;
                                res.tx_byte    = {slave_reg, 1'b1};
                                phase_next     = PH_R_MODE;
                            end
                        end
                        PH_R_MODE:
                        begin
                            if (item.addr_acked)
                            begin
                                phase_next = PH_R_RECV;
                            end
                        end
                        PH_R_RECV:
                        begin
                            if (item.rx_full)
                            begin
                                res.rx_valid = 1'b1;
                                res.rx_index = pos_reg[7:0];
                                res.rx_byte  = item.data_byte;
                                pos_next     = pos_reg + 9'd1;
                                if (({1'b0, pos_reg} + 10'd1) >= {1'b0, count_reg})
                                begin
                                    ack_next       = 1'b0;
                                    res.bus_action = ACT_STOP;
                                    res.done_res   = 1'b1;
                                    phase_next     = PH_IDLE;
                                end
                            end
                        end
                        PH_T_ADDR:
                        begin
                            if (item.nack_seen)
                            begin
                                res.bus_action = ACT_START;
                                phase_next     = PH_T_START;
                            end
                            else if (item.addr_acked)
                            begin
                                res.bus_action = ACT_SEND;
                                res.tx_byte    = {3'd0, maddr_reg[12:8]};
                                phase_next     = PH_T_ADDR2;
                            end
                        end
                        PH_T_NEXT:
                        begin
                            if (item.tx_empty)
                            begin
                                if (pos_reg < count_reg)
                                begin
                                    res.bus_action = ACT_SEND;
                                    res.tx_byte    = store_byte;
                                    pos_next       = pos_reg + 9'd1;
                                end
                                else
                                begin
                                    phase_next = PH_T_LAST;
                                end
                            end
                        end
                        PH_T_LAST:
                        begin
                            if (item.byte_done)
                            begin
                                res.bus_action = ACT_STOP;
                                res.done_res   = 1'b1;
                                phase_next     = PH_IDLE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            endcase
        end
        res.ack_enable = ack_next;
        res.busy_res   = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            slave_reg     <= '0;
            maddr_reg     <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            ack_reg       <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            slave_reg     <= slave_next;
            maddr_reg     <= maddr_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            ack_reg       <= ack_next;
            fwd_valid_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_addr_reg <= wr_addr;
        fwd_data_reg <= item.data_byte;
        rd_addr_reg  <= rd_addr;
    end

endmodule

[src/i2cee_outbuf.sv]
module i2cee_outbuf (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  i2cee_pkg::res_t                   res,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [i2cee_pkg::M_TDATA_W-1:0]   m_tdata
);
    import i2cee_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    res_t         data_reg;

    assign in_ready   = !valid_reg || m_tready;
    assign valid_next = in_valid || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, data_reg};

endmodule

[src/i2c_eeprom_master_sequencer.sv]
// I2C master sequencer for an EEPROM with a 13-bit memory address.
// The slave channel takes one item per handshake: a command (load a transmit
// byte, start a random read, start a page write) or one bus status event, with
// the kind on s_tuser. The master channel returns exactly one result item for
// every accepted item, naming the next bus action and reporting received bytes,
// the acknowledge enable, completion and busy.
// A result is registered and appears on m_tvalid the cycle after its item
// is accepted. Throughput is one item per cycle while m_tready is high. The
// transmit bytes sit in a synchronous store with a registered read; it is
// always read ahead at the next byte position, and a load to that position
// in the same cycle is forwarded. When the receiver stalls, the result is
// held in the output register and a new item is accepted only in a cycle in
// which that register is taken or empty, so s_tready follows m_tready.
// Reset puts the sequencer in idle with all addresses, counts and the
// acknowledge enable cleared and no result pending. The transmit store is not
// cleared: a write must only send bytes that were loaded before.
module i2c_eeprom_master_sequencer #(
    parameter int unsigned BUF_DEPTH = i2cee_pkg::BUF_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // dev_addr, mem_addr, length, data_byte, load_index, start_sent,
    // addr_acked, tx_empty, rx_full, byte_done, nack_seen, zero pad
    input  logic [i2cee_pkg::S_TDATA_W-1:0]   s_tdata,
    // cmd
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // bus_action, tx_byte, ack_enable, rx_valid, rx_index, rx_byte,
    // done_res, busy_res, zero pad
    output logic [i2cee_pkg::M_TDATA_W-1:0]   m_tdata
);
    import i2cee_pkg::*;

    item_t item;
    res_t  res;
    logic  in_fire;

    assign item    = s_tdata[$bits(item_t)-1:0];
    assign in_fire = s_tvalid && s_tready;

    i2cee_ctrl #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .cmd     (s_tuser),
        .item    (item),
        .res     (res)
    );

    i2cee_outbuf u_outbuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_fire),
        .in_ready (s_tready),
        .res      (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[src/i2cee_checker.sv]
module i2cee_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [i2cee_pkg::S_TDATA_W-1:0]   s_tdata,
    input logic [1:0]                        s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [i2cee_pkg::M_TDATA_W-1:0]   m_tdata
);
    import i2cee_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Stalled result item changed or dropped.");

    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("Accepted item produced no result item.");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("Input stalled with an empty output register.");

    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[29] |-> (m_tdata[2:0] == ACT_STOP) && !m_tdata[30])
        else $error("Completion without stop or while still busy.");

    a_rx: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[12] |-> m_tdata[30] || m_tdata[29])
        else $error("Received byte reported outside a read.");

endmodule

bind i2c_eeprom_master_sequencer i2cee_checker u_i2cee_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    import i2cee_pkg::*;

    localparam logic [5:0] F_START = 6'b000001;
    localparam logic [5:0] F_ADDR  = 6'b000010;
    localparam logic [5:0] F_TXE   = 6'b000100;
    localparam logic [5:0] F_RXF   = 6'b001000;
    localparam logic [5:0] F_BTF   = 6'b010000;
    localparam logic [5:0] F_NACK  = 6'b100000;
    localparam logic [5:0] F_ALL   = 6'b111111;

    localparam int RANDOM_ITEMS = 850;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0]           s_tuser = CMD_LOAD;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    logic [3:0]  seq_phase = PH_IDLE;
    logic [6:0]  seq_slave = '0;
    logic [12:0] seq_mem = '0;
    logic [8:0]  seq_count = '0;
    logic [8:0]  seq_pos = '0;
    logic        seq_ack = 1'b0;
    logic [7:0]  tx_shadow [0:255];
    bit          store_loaded [0:255];

    res_t expected_results [$];
    res_t got_res;
    res_t want_res;
    int   fail_count = 0;
    int   items_sent = 0;
    bit   steady = 1'b0;

    i2c_eeprom_master_sequencer u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic res_t predict_step(input logic [1:0] cmd, input item_t it);
        res_t r;
        r = '0;
        case (cmd)
            CMD_LOAD:
            begin
                tx_shadow[it.load_index] = it.data_byte;
                store_loaded[it.load_index] = 1'b1;
            end
            CMD_READ, CMD_WRITE:
            begin
                if (seq_phase == PH_IDLE)
                begin
                    seq_slave = it.dev_addr;
                    seq_mem   = it.mem_addr;
                    seq_count = it.length;
                    seq_pos   = '0;
                    if (cmd == CMD_READ)
                    begin
                        seq_ack   = 1'b1;
                        seq_phase = PH_R_START;
                    end
                    else
                    begin
                        seq_phase = PH_T_START;
                    end
                    r.bus_action = ACT_START;
                end
            end
            default:
            begin
                case (seq_phase)
                    PH_R_START, PH_T_START:
                    begin
                        if (it.start_sent)
                        begin
                            r.bus_action = ACT_AWR;
                            r.tx_byte    = {seq_slave, 1'b0};
                            seq_phase    = (seq_phase == PH_R_START) ? PH_R_WADDR : PH_T_ADDR;
                        end
                    end
                    PH_R_WADDR:
                    begin
                        if (it.addr_acked)
                        begin
                            r.bus_action = ACT_SEND;
                            r.tx_byte    = {3'b000, seq_mem[12:8]};
                            seq_phase    = PH_R_WADDR2;
                        end
                    end
                    PH_R_WADDR2, PH_T_ADDR2:
                    begin
                        if (it.tx_empty)
                        begin
                            r.bus_action = ACT_SEND;
                            r.tx_byte    = seq_mem[7:0];
                            seq_phase    = (seq_phase == PH_R_WADDR2) ? PH_R_DAWRITE : PH_T_NEXT;
                        end
                    end
                    PH_R_DAWRITE:
                    begin
                        if (it.tx_empty)
                        begin
                            r.bus_action = ACT_START;
                            seq_phase    = PH_R_ADDR;
                        end
                    end
                    PH_R_ADDR:
                    begin
                        if (it.start_sent)
                        begin
                            r.bus_action = ACT_ARD;
                            r.tx_byte    = {seq_slave, 1'b1};
                            seq_phase    = PH_R_MODE;
                        end
                    end
                    PH_R_MODE:
                    begin
                        if (it.addr_acked)
                        begin
                            seq_phase = PH_R_RECV;
                        end
                    end
                    PH_R_RECV:
                    begin
                        if (it.rx_full)
                        begin
                            r.rx_valid = 1'b1;
                            r.rx_index = seq_pos[7:0];
                            r.rx_byte  = it.data_byte;
                            if (({1'b0, seq_pos} + 10'd1) >= {1'b0, seq_count})
                            begin
                                seq_ack      = 1'b0;
                                r.bus_action = ACT_STOP;
                                r.done_res   = 1'b1;
                                seq_phase    = PH_IDLE;
                            end
                            seq_pos = seq_pos + 9'd1;
                        end
                    end
                    PH_T_ADDR:
                    begin
                        if (it.nack_seen)
                        begin
                            r.bus_action = ACT_START;
                            seq_phase    = PH_T_START;
                        end
                        else if (it.addr_acked)
                        begin
                            r.bus_action = ACT_SEND;
                            r.tx_byte    = {3'b000, seq_mem[12:8]};
                            seq_phase    = PH_T_ADDR2;
                        end
                    end
                    PH_T_NEXT:
                    begin
                        if (it.tx_empty)
                        begin
                            if (seq_pos < seq_count)
                            begin
                                r.bus_action = ACT_SEND;
                                r.tx_byte    = tx_shadow[seq_pos[7:0]];
                                seq_pos      = seq_pos + 9'd1;
                            end
                            else
                            begin
                                seq_phase = PH_T_LAST;
                            end
                        end
                    end
                    PH_T_LAST:
                    begin
                        if (it.byte_done)
                        begin
                            r.bus_action = ACT_STOP;
                            r.done_res   = 1'b1;
                            seq_phase    = PH_IDLE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        endcase
        r.ack_enable = seq_ack;
        r.busy_res   = (seq_phase != PH_IDLE);
        return r;
    endfunction

    function automatic logic [5:0] awaited_flag(input logic [3:0] ph);
        case (ph)
            PH_R_START, PH_R_ADDR, PH_T_START:             return F_START;
            PH_R_WADDR, PH_R_MODE, PH_T_ADDR:              return F_ADDR;
            PH_R_WADDR2, PH_R_DAWRITE, PH_T_ADDR2, PH_T_NEXT: return F_TXE;
            PH_R_RECV:                                     return F_RXF;
            PH_T_LAST:                                     return F_BTF;
            default:                                       return '0;
        endcase
    endfunction

    function automatic item_t rand_item();
        item_t it;
        it.dev_addr   = 7'($urandom);
        it.mem_addr   = 13'($urandom);
        it.length     = 9'($urandom_range(0, 256));
        it.data_byte  = 8'($urandom);
        it.load_index = 8'($urandom);
        {it.nack_seen, it.byte_done, it.rx_full, it.tx_empty, it.addr_acked, it.start_sent} =
            6'($urandom);
        return it;
    endfunction

    function automatic logic [8:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            return 9'd256;
        end
        else if (r < 10)
        begin
            return 9'($urandom_range(9, 255));
        end
        return 9'($urandom_range(0, 8));
    endfunction

    task automatic send_item(input logic [1:0] cmd, input item_t it);
        if (!steady && $urandom_range(0, 99) < 15)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 2)) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(S_TDATA_W - $bits(item_t)){1'b0}}, it};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        expected_results.push_back(predict_step(cmd, it));
        items_sent++;
    endtask

    task automatic send_event(input logic [5:0] flags, input logic [7:0] rx_data);
        item_t it;
        it = rand_item();
        {it.nack_seen, it.byte_done, it.rx_full, it.tx_empty, it.addr_acked, it.start_sent} =
            flags;
        it.data_byte = rx_data;
        send_item(CMD_EVENT, it);
    endtask

    task automatic send_load(input logic [7:0] idx, input logic [7:0] value);
        item_t it;
        it = rand_item();
        it.load_index = idx;
        it.data_byte  = value;
        send_item(CMD_LOAD, it);
    endtask

    task automatic send_start(input logic [1:0] cmd, input logic [6:0] dev,
                              input logic [12:0] mem, input logic [8:0] len);
        item_t it;
        it = rand_item();
        it.dev_addr = dev;
        it.mem_addr = mem;
        it.length   = len;
        send_item(cmd, it);
    endtask

    task automatic test_idle_events();
        send_event(F_ALL, 8'hFF);
        send_event('0, 8'h00);
        send_load(8'hFF, 8'hFF);
    endtask

    // Shortest read with the widest addresses; zero length still fetches one byte.
    task automatic test_read_min_length();
        send_start(CMD_READ, 7'h7F, 13'h1FFF, 9'd0);
        send_event(F_ALL & ~F_START, 8'h11);
        send_event(F_START, 8'h00);
        send_event(F_ADDR | F_NACK, 8'h00);
        send_event(F_TXE, 8'h00);
        send_event(F_TXE | F_BTF, 8'h00);
        send_event(F_START, 8'h00);
        send_event(F_ADDR, 8'h00);
        send_event(F_RXF | F_NACK, 8'hFF);
    endtask

    task automatic test_write_nack_restart();
        send_load(8'h00, 8'h00);
        send_load(8'h01, 8'h5A);
        send_start(CMD_WRITE, 7'h00, 13'h0000, 9'd2);
        send_event(F_START, 8'h00);
        send_event(F_NACK | F_ADDR, 8'h00);
        send_event(F_START, 8'h00);
        send_start(CMD_READ, 7'h7F, 13'h1FFF, 9'd256);
        send_event(F_ADDR, 8'h00);
        send_event(F_TXE, 8'h00);
        send_event(F_TXE, 8'h00);
        send_event(F_TXE, 8'h00);
        send_load(8'h01, 8'hA5);
        send_event(F_TXE, 8'h00);
        send_event(F_ALL & ~F_TXE, 8'h00);
        send_event(F_TXE, 8'h00);
        send_event(F_BTF, 8'h00);
    endtask

    task automatic run_transfer(input logic [1:0] cmd);
        item_t      it;
        logic [5:0] flags;
        int         r;
        it = rand_item();
        it.length = pick_length();
        if (cmd == CMD_WRITE)
        begin
            for (int i = 0; i < it.length; i++)
            begin
                if (!store_loaded[i % 256])
                begin
                    send_load(8'(i), 8'($urandom));
                end
            end
        end
        send_item(cmd, it);
        while (seq_phase != PH_IDLE)
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
            begin
                send_load(8'($urandom), 8'($urandom));
            end
            else if (r < 10)
            begin
                send_item($urandom_range(0, 1) ? CMD_READ : CMD_WRITE, rand_item());
            end
            else
            begin
                flags = 6'($urandom);
                if ($urandom_range(0, 99) < 80)
                begin
                    flags = flags | awaited_flag(seq_phase);
                    if (seq_phase == PH_T_ADDR)
                    begin
                        flags = flags & ~F_NACK;
                    end
                end
                send_event(flags, 8'($urandom));
            end
        end
    endtask

    task automatic test_random_traffic();
        int first;
        int r;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS)
        begin
            steady = (items_sent - first >= 300) && (items_sent - first < 420);
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                run_transfer(CMD_READ);
            end
            else if (r < 90)
            begin
                run_transfer(CMD_WRITE);
            end
            else if (r < 95)
            begin
                send_load(8'($urandom), 8'($urandom));
            end
            else
            begin
                send_item(CMD_EVENT, rand_item());
            end
        end
        steady = 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            m_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 15);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_res = res_t'(m_tdata[$bits(res_t)-1:0]);
            if (expected_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display("unexpected result: %h", got_res);
                end
            end
            else
            begin
                want_res = expected_results.pop_front();
                if (got_res !== want_res)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("mismatch: act %0d/%0d txb %h/%h ack %b/%b rxv %b/%b",
                                 want_res.bus_action, got_res.bus_action,
                                 want_res.tx_byte, got_res.tx_byte,
                                 want_res.ack_enable, got_res.ack_enable,
                                 want_res.rx_valid, got_res.rx_valid);
                        $display("    rxi %h/%h rxb %h/%h done %b/%b busy %b/%b",
                                 want_res.rx_index, got_res.rx_index,
                                 want_res.rx_byte, got_res.rx_byte,
                                 want_res.done_res, got_res.done_res,
                                 want_res.busy_res, got_res.busy_res);
                    end
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("[i2c_eeprom_master_sequencer] ERROR");
        $finish;
    end

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        test_idle_events();
        test_read_min_length();
        test_write_nack_restart();
        test_random_traffic();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (5) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("[i2c_eeprom_master_sequencer] OK");
        end
        else
        begin
            $display("[i2c_eeprom_master_sequencer] ERROR");
        end
        $finish;
    end

endmodule
